>>> rtl/pes_pkg.sv
package pes_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_ON_Y  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HOLD,
    ST_SCAN,
    ST_WRBACK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic              wr_held;
    logic [ADDR_W-1:0] raddr;
    logic              held_ld;
    logic              out_ld;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic swap;
    logic out_free;
  } status_t;

endpackage

>>> rtl/point_exchange_sorter.sv
// channel  direction  word                                   handshake
// s_*      in         tdata: in_x, in_y; tlast: in_last      s_tvalid / s_tready
// m_*      out        tdata: out_x, out_y; tlast: out_last   m_tvalid / m_tready
// cfg_*    in         cfg_index, cfg_data                    cfg_valid / cfg_ready
//
// a point is stored while fewer than 64 are held; the word marked last
// starts the sort of 2 or more points, one compare per cycle in ST_SCAN
// on the simple dual-port point store (one read, one write per cycle).
// output: registers rdata and out_point lie between store and m_*.
// input is stalled during sort and output; a waiting last output word does
// not block a new set. rst is synchronous and empties the set.
module point_exchange_sorter
  import pes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [2*COORD_W-1:0] s_tdata,   // in_x [31:0], in_y [63:32]
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [2*COORD_W-1:0] m_tdata,   // out_x [31:0], out_y [63:32]
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  pes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pes_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> rtl/pes_datapath.sv
module pes_datapath
  import pes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2*COORD_W-1:0] s_tdata,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [2*COORD_W-1:0] m_tdata,
  output logic                 m_tlast
);

  point_t mem [MAX_POINTS];
  point_t rdata;
  point_t held;
  point_t in_point;
  point_t out_point;
  logic   sort_on_y;
  logic   descending;
  logic signed [COORD_W-1:0] key_held;
  logic signed [COORD_W-1:0] key_rd;

  assign in_point.x = s_tdata[COORD_W-1:0];
  assign in_point.y = s_tdata[2*COORD_W-1:COORD_W];

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.waddr] <= cmd.wr_held ? held : in_point;
    end
    rdata <= mem[cmd.raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.held_ld) begin
      held <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_on_y  <= 1'b0;
      descending <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SORT_ON_Y:  sort_on_y  <= cfg_data;
        CFG_DESCENDING: descending <= cfg_data;
        default: ;
      endcase
    end
  end

  // held is the entry at position i, rdata the entry at position j
  always_comb begin
    key_held = sort_on_y ? held.y : held.x;
    key_rd   = sort_on_y ? rdata.y : rdata.x;
    status.swap     = descending ? (key_rd > key_held) : (key_held > key_rd);
    status.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_point <= rdata;
      m_tlast   <= cmd.out_last;
    end
  end

  assign m_tdata = {out_point.y, out_point.x};

endmodule

>>> rtl/pes_ctrl.sv
module pes_ctrl
  import pes_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_tlast,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  n, n_next;
  logic [ADDR_W-1:0] i, i_next;
  logic [ADDR_W-1:0] j, j_next;
  logic [ADDR_W-1:0] k, k_next;
  logic              room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;
    i <= i_next;
    j <= j_next;
    k <= k_next;
  end

  assign room = (count < CNT_W'(MAX_POINTS));

  always_comb begin
    state_next = state;
    count_next = count;
    n_next     = n;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    s_tready   = 1'b0;
    cmd        = '0;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (room) begin
            cmd.mem_we = 1'b1;
            cmd.waddr  = count[ADDR_W-1:0];
            count_next = count + CNT_W'(1);
          end
          if (s_tlast) begin
            n_next     = room ? count + CNT_W'(1) : count;
            count_next = '0;
            i_next     = '0;
            k_next     = '0;
            state_next = (n_next >= CNT_W'(2)) ? ST_LOAD : ST_EMIT_RD;
          end
        end
      end
      ST_LOAD: begin
        cmd.raddr  = i;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        cmd.held_ld = 1'b1;
        cmd.raddr   = i + ADDR_W'(1);
        j_next      = i + ADDR_W'(1);
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        // read of j+1 overlaps the compare and write-back of j
        if (status.swap) begin
          cmd.mem_we  = 1'b1;
          cmd.waddr   = j;
          cmd.wr_held = 1'b1;
          cmd.held_ld = 1'b1;
        end
        if (CNT_W'(j) + CNT_W'(1) < n) begin
          cmd.raddr = j + ADDR_W'(1);
          j_next    = j + ADDR_W'(1);
        end else begin
          state_next = ST_WRBACK;
        end
      end
      ST_WRBACK: begin
        cmd.mem_we  = 1'b1;
        cmd.waddr   = i;
        cmd.wr_held = 1'b1;
        if (CNT_W'(i) + CNT_W'(2) < n) begin
          i_next     = i + ADDR_W'(1);
          state_next = ST_LOAD;
        end else begin
          k_next     = '0;
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.raddr  = k;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd.raddr = k;
        if (status.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_last = (CNT_W'(k) + CNT_W'(1) == n);
          if (cmd.out_last) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + ADDR_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
